@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Clock is clk, reset is rst in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define HRFB_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante.
`define HRFB_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hrfb_pkg.sv @@
// ----------------------------------------------------------------------------
// hrfb_pkg
// Types and constants shared by the request frame builder modules.
// ----------------------------------------------------------------------------
package hrfb_pkg;

  localparam int MAX_PREAMBLE = 20;
  localparam int PRE_W        = $clog2(MAX_PREAMBLE + 1);

  // configuration register indexes
  localparam int          CFG_IDX_W    = 2;
  localparam logic [1:0]  REG_PREAMBLE = 2'd0;
  localparam logic [1:0]  REG_LONG     = 2'd1;
  localparam logic [1:0]  REG_ADDR     = 2'd2;

  localparam logic [4:0]  PREAMBLE_RESET = 5'd5;

  localparam logic [7:0]  PREAMBLE_BYTE = 8'hFF;
  localparam logic [7:0]  DELIM_SHORT   = 8'h02;
  localparam logic [7:0]  DELIM_LONG    = 8'h82;
  localparam logic [7:0]  CSUM_HI_MASK  = 8'hF0;
  localparam logic [7:0]  CSUM_LO_MASK  = 8'h0F;

  // queue entry kinds
  localparam logic [1:0]  KIND_START = 2'd0;
  localparam logic [1:0]  KIND_DATA  = 2'd1;
  localparam logic [1:0]  KIND_ERROR = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] command;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       last_of_run;
    logic       error;
  } out_t;

  typedef struct packed {
    logic [PRE_W-1:0] preamble;
    logic             long_frame;
    logic [39:0]      address;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       closes;   // word ends the frame: checksum follows
    logic [7:0] command;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
  } entry_t;

endpackage

@@ src/hrfb_fifo.sv @@
// ----------------------------------------------------------------------------
// hrfb_fifo
// Two-entry queue between the classifier and the frame sequencer.
// ----------------------------------------------------------------------------
module hrfb_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hrfb_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output hrfb_pkg::entry_t head,
  output logic            head_valid
);
  import hrfb_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

@@ src/hrfb_front.sv @@
// ----------------------------------------------------------------------------
// hrfb_front
// Config registers and item classifier: tracks the open frame's remaining
// count and tags each word as start, data or error before queueing it.
// ----------------------------------------------------------------------------
module hrfb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hrfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [39:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hrfb_pkg::in_t                   in_data,
  output logic                            push,
  output hrfb_pkg::entry_t                push_entry,
  input  logic                            q_full,
  output hrfb_pkg::cfg_t                  cfg
);
  import hrfb_pkg::*;

  logic [4:0]  preamble_length;
  logic        long_frame;
  logic [39:0] device_address;
  logic [7:0]  bytes_remaining;
  logic [7:0]  bytes_remaining_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~q_full;
  assign push      = in_valid & ~q_full;

  // saturate the preamble length
  always_comb begin
    if (int'(preamble_length) > MAX_PREAMBLE) cfg.preamble = PRE_W'(MAX_PREAMBLE);
    else                                      cfg.preamble = PRE_W'(preamble_length);
    cfg.long_frame = long_frame;
    cfg.address    = device_address;
  end

  always_comb begin
    push_entry.command    = in_data.command;
    push_entry.byte_count = in_data.byte_count;
    push_entry.data_byte  = in_data.data_byte;
    push_entry.kind       = KIND_START;
    push_entry.closes     = 1'b0;
    bytes_remaining_next  = bytes_remaining;
    if (!in_data.mode) begin
      push_entry.closes    = (in_data.byte_count == 8'd0);
      bytes_remaining_next = in_data.byte_count;
    end else if (bytes_remaining == 8'd0) begin
      // no open frame waiting for data
      push_entry.kind = KIND_ERROR;
    end else begin
      push_entry.kind      = KIND_DATA;
      push_entry.closes    = (bytes_remaining == 8'd1);
      bytes_remaining_next = bytes_remaining - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_length <= PREAMBLE_RESET;
      long_frame      <= 1'b0;
      device_address  <= 40'd0;
      bytes_remaining <= 8'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_PREAMBLE: preamble_length <= cfg_data[4:0];
          REG_LONG:     long_frame      <= cfg_data[0];
          REG_ADDR:     device_address  <= cfg_data;
          default:      ;
        endcase
      end
      if (push) bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

@@ src/hrfb_back.sv @@
// ----------------------------------------------------------------------------
// hrfb_back
// Frame sequencer: a start entry gives preamble, delimiter, address, command
// and count, a data entry its byte, each then the checksum if it closes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrfb_back (
  input  logic             clk,
  input  logic             rst,
  input  hrfb_pkg::cfg_t   cfg,
  input  hrfb_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output hrfb_pkg::out_t   out_data
);
  import hrfb_pkg::*;

  localparam logic [2:0] PH_HEAD  = 3'd0;
  localparam logic [2:0] PH_PRE   = 3'd1;
  localparam logic [2:0] PH_DELIM = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_CMD   = 3'd4;
  localparam logic [2:0] PH_CNT   = 3'd5;
  localparam logic [2:0] PH_CSUM  = 3'd6;

  logic [2:0]       phase, phase_next;
  logic [PRE_W-1:0] pre_cnt, pre_cnt_next;
  logic [2:0]       addr_idx, addr_idx_next;
  logic [7:0]       checksum, checksum_next;
  logic             step;
  logic             emit;
  out_t             word;
  logic [7:0]       addr_byte;

  assign step = head_valid & (~out_valid | out_ready);

  always_comb begin
    case (addr_idx)
      3'd0:    addr_byte = cfg.address[39:32];
      3'd1:    addr_byte = cfg.address[31:24];
      3'd2:    addr_byte = cfg.address[23:16];
      3'd3:    addr_byte = cfg.address[15:8];
      default: addr_byte = cfg.address[7:0];
    endcase
  end

  always_comb begin
    phase_next    = phase;
    pre_cnt_next  = pre_cnt;
    addr_idx_next = addr_idx;
    checksum_next = checksum;
    emit          = 1'b0;
    pop           = 1'b0;
    word          = '0;
    if (step) begin
      case (phase)
        PH_HEAD: begin
          case (head.kind)
            KIND_START: begin
              // setup step, no byte out
              checksum_next = 8'd0;
              pre_cnt_next  = '0;
              addr_idx_next = 3'd0;
              phase_next    = (cfg.preamble == '0) ? PH_DELIM : PH_PRE;
            end
            KIND_DATA: begin
              emit            = 1'b1;
              word.frame_byte = head.data_byte;
              checksum_next   = checksum ^ head.data_byte;
              if (head.closes) begin
                phase_next = PH_CSUM;
              end else begin
                word.last_of_run = 1'b1;
                pop              = 1'b1;
              end
            end
            default: begin
              emit             = 1'b1;
              word.error       = 1'b1;
              word.last_of_run = 1'b1;
              pop              = 1'b1;
            end
          endcase
        end
        PH_PRE: begin
          emit            = 1'b1;
          word.frame_byte = PREAMBLE_BYTE;
          pre_cnt_next    = pre_cnt + PRE_W'(1);
          if (pre_cnt == cfg.preamble - PRE_W'(1)) phase_next = PH_DELIM;
        end
        PH_DELIM: begin
          emit            = 1'b1;
          word.frame_byte = cfg.long_frame ? DELIM_LONG : DELIM_SHORT;
          checksum_next   = checksum ^ word.frame_byte;
          phase_next      = PH_ADDR;
        end
        PH_ADDR: begin
          emit            = 1'b1;
          word.frame_byte = addr_byte;
          checksum_next   = checksum ^ addr_byte;
          addr_idx_next   = addr_idx + 3'd1;
          if (!cfg.long_frame || addr_idx == 3'd4) phase_next = PH_CMD;
        end
        PH_CMD: begin
          emit            = 1'b1;
          word.frame_byte = head.command;
          checksum_next   = checksum ^ head.command;
          phase_next      = PH_CNT;
        end
        PH_CNT: begin
          emit            = 1'b1;
          word.frame_byte = head.byte_count;
          checksum_next   = checksum ^ head.byte_count;
          if (head.closes) begin
            phase_next = PH_CSUM;
          end else begin
            word.last_of_run = 1'b1;
            pop              = 1'b1;
            phase_next       = PH_HEAD;
          end
        end
        PH_CSUM: begin
          emit             = 1'b1;
          word.frame_byte  = (checksum & CSUM_HI_MASK) | (checksum & CSUM_LO_MASK);
          word.frame_end   = 1'b1;
          word.last_of_run = 1'b1;
          checksum_next    = 8'd0;
          pop              = 1'b1;
          phase_next       = PH_HEAD;
        end
        default: begin
          phase_next = PH_HEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEAD;
      checksum  <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      checksum <= checksum_next;
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pre_cnt  <= pre_cnt_next;
    addr_idx <= addr_idx_next;
    if (emit) out_data <= word;
  end

  `HRFB_CHECK(a_end_is_last, (out_valid && out_data.frame_end) |-> out_data.last_of_run,
              "checksum word not marked last")
  `HRFB_CHECK(a_err_clean,
              (out_valid && out_data.error) |->
                (out_data.frame_byte == 8'd0 && !out_data.frame_end),
              "error word carries frame content")
  `HRFB_CHECK_NEXT(a_pop_resets, pop, phase == PH_HEAD, "entry retired mid-sequence")
  `HRFB_CHECK(a_pop_needs_head, pop |-> (head_valid && emit), "pop without an emitted word")

endmodule

@@ src/hart_request_frame_builder.sv @@
// ----------------------------------------------------------------------------
// hart_request_frame_builder
// Serialises a HART master request frame, one byte per output word.
//  - in (in_valid/in_ready/in_data): mode 0 starts a frame with command and
//    byte_count, mode 1 supplies one payload byte.
//  - out (out_valid/out_ready/out_data): one frame byte per word; frame_end
//    on the checksum, last_of_run on the last word of each input word. A
//    data word with no frame expecting data gives a zero byte with error.
//  - cfg: index 0 preamble length (capped at MAX_PREAMBLE), 1 long frame,
//    2 the 40-bit address. cfg_ready is always high; write only while idle.
//  - Sequence: a data word gives its byte, then the checksum when it closes
//    the frame. A start takes a setup step, then emits in order: preamble,
//    delimiter, address (1 or 5 bytes), command, count and, for a zero count,
//    the checksum. A two-entry queue lets input flow while a header drains.
//  - Reset (rst, synchronous): preamble 5, short frame, address 0, no frame
//    open, queue and output empty.
//  - A stalled receiver holds the output word; the queue fills and in_ready
//    drops.
// ----------------------------------------------------------------------------
module hart_request_frame_builder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hrfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [39:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hrfb_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hrfb_pkg::out_t                 out_data
);
  import hrfb_pkg::*;

  // classifier to queue
  logic   push;
  entry_t push_entry;
  logic   q_full;
  // queue to sequencer
  entry_t head;
  logic   head_valid;
  logic   pop;
  // saturated configuration seen by the sequencer
  cfg_t   cfg;

  hrfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full),
    .cfg        (cfg)
  );

  hrfb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  hrfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
